/* src/ksa_pkg.sv */
// ksa_pkg: shared types and constants of the keyed stat accumulator.
// No dependencies; keyed_stat_accumulator, ksa_front and ksa_back use it by scoped names.
package ksa_pkg;

   localparam int KEY_IN_BITS    = 16;
   localparam int INC_BITS       = 16;
   localparam int SLOT_BITS      = 4;
   localparam int TOTAL_OUT_BITS = 32;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic [1:0] {
      ST_ACCUM   = 2'd0,
      ST_INSERT  = 2'd1,
      ST_FULL    = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

   typedef struct packed {
      logic [KEY_IN_BITS-1:0] player_key;
      logic [INC_BITS-1:0]    inc_games;
      logic [INC_BITS-1:0]    inc_hits;
      logic [INC_BITS-1:0]    inc_bases;
      logic [INC_BITS-1:0]    inc_runs;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [SLOT_BITS-1:0]      slot;
      logic [TOTAL_OUT_BITS-1:0] total_games;
      logic [TOTAL_OUT_BITS-1:0] total_hits;
      logic [TOTAL_OUT_BITS-1:0] total_bases;
      logic [TOTAL_OUT_BITS-1:0] total_runs;
   } rsp_type;

   // Classified transaction handed from the front to the back.
   typedef struct packed {
      status_type          status;
      logic [INC_BITS-1:0] inc_games;
      logic [INC_BITS-1:0] inc_hits;
      logic [INC_BITS-1:0] inc_bases;
      logic [INC_BITS-1:0] inc_runs;
   } work_type;

   localparam int WORK_BITS = $bits(work_type);

endpackage

/* src/ksa_stream_if.sv */
// ksa_stream_if: valid/ready channel carrying one payload of type T.
// Used for the request and response channels; payload types come from ksa_pkg.
interface ksa_stream_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* src/keyed_stat_accumulator.sv */
// keyed_stat_accumulator: top level, associative counter table with four totals.
// Depends on ksa_pkg, ksa_stream_if, ksa_front, ksa_queue and ksa_back.
//
//   channel  direction  payload             accepted when
//   req_ch   in         ksa_pkg::req_type   req_ch.valid && req_ch.ready
//   rsp_ch   out        ksa_pkg::rsp_type   rsp_ch.valid && rsp_ch.ready
//
// The front takes one request per cycle while the two-entry queue has room;
// the key lookup is a parallel compare against the key registers.
// The back does an accumulate as a totals RAM read in BK_IDLE, then the write in BK_READ,
// and handles an insert or a rejected transaction in BK_IDLE alone.
// Reset is synchronous and clears the fill count, queue and back control;
// the key registers and totals RAM need no clearing pass.
// A stalled response holds in the output register; the front keeps accepting
// until the queue fills.
module keyed_stat_accumulator #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 16,
   parameter int TOTAL_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   ksa_stream_if.sink   req_ch,
   ksa_stream_if.source rsp_ch
);

   localparam int IDX_BITS = $clog2(ENTRIES);
   localparam int Q_WIDTH  = IDX_BITS + ksa_pkg::WORK_BITS;

   logic                    push;
   ksa_pkg::work_type       push_work;
   logic [IDX_BITS-1:0]     push_idx;
   logic                    q_full;
   logic                    q_empty;
   logic                    q_pop;
   logic [Q_WIDTH-1:0]      q_data;
   ksa_pkg::work_type       q_work;
   logic [IDX_BITS-1:0]     q_idx;

   ksa_front #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .q_full    (q_full),
      .push      (push),
      .push_work (push_work),
      .push_idx  (push_idx)
   );

   ksa_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (ksa_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_idx, push_work}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   assign q_idx  = q_data[Q_WIDTH-1 -: IDX_BITS];
   assign q_work = ksa_pkg::work_type'(q_data[ksa_pkg::WORK_BITS-1:0]);

   ksa_back #(
      .ENTRIES    (ENTRIES),
      .TOTAL_BITS (TOTAL_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_work  (q_work),
      .q_idx   (q_idx),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

/* src/ksa_ram.sv */
// ksa_ram: generic single-write, single-read RAM with registered read data.
// Standalone; instantiated by ksa_back for the running totals.
module ksa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ksa_queue.sv */
// ksa_queue: small flop FIFO that decouples the front from the back.
// Standalone; payload packing is done by the instantiating module.
module ksa_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !(push && !pop))
      else $error("queue write while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && pop) |=> $stable(count_ff))
      else $error("queue count moved on simultaneous push and pop");
`endif

endmodule

/* src/ksa_front.sv */
// ksa_front: accepts requests, looks the key up in the key table and classifies.
// Owns the key table and fill count; depends on ksa_pkg and ksa_stream_if.
module ksa_front #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   ksa_stream_if.sink                 req,
   input  logic                       q_full,
   output logic                       push,
   output ksa_pkg::work_type          push_work,
   output logic [$clog2(ENTRIES)-1:0] push_idx
);

   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int FILL_BITS = $clog2(ENTRIES + 1);

   logic [KEY_BITS-1:0]  key_ff [ENTRIES];
   logic [FILL_BITS-1:0] fill_count_ff, fill_count_in;

   logic [KEY_BITS-1:0]  key_m;
   logic [ENTRIES-1:0]   hit;
   logic [IDX_BITS-1:0]  hit_idx;
   logic                 found;
   logic                 table_full;
   logic                 accept;
   ksa_pkg::status_type  status;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      key_m = '0;
      for (int b = 0; b < KEY_BITS; b++) begin
         if (b < ksa_pkg::KEY_IN_BITS) begin
            key_m[b] = req.data.player_key[b];
         end
      end
   end

   // Stored keys are unique, so at most one hit; OR the indexes together.
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit[i] = (FILL_BITS'(i) < fill_count_ff) && (key_ff[i] == key_m);
         if (hit[i]) begin
            hit_idx = hit_idx | IDX_BITS'(i);
         end
      end
      found      = |hit;
      table_full = (fill_count_ff == FILL_BITS'(ENTRIES));
   end

   always_comb begin
      if (key_m == '0) begin
         status = ksa_pkg::ST_INVALID;
      end else if (found) begin
         status = ksa_pkg::ST_ACCUM;
      end else if (table_full) begin
         status = ksa_pkg::ST_FULL;
      end else begin
         status = ksa_pkg::ST_INSERT;
      end
   end

   always_comb begin
      push                = accept;
      push_work.status    = status;
      push_work.inc_games = req.data.inc_games;
      push_work.inc_hits  = req.data.inc_hits;
      push_work.inc_bases = req.data.inc_bases;
      push_work.inc_runs  = req.data.inc_runs;
      case (status)
         ksa_pkg::ST_ACCUM:  push_idx = hit_idx;
         ksa_pkg::ST_INSERT: push_idx = fill_count_ff[IDX_BITS-1:0];
         default:            push_idx = '0;
      endcase
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      if (accept && (status == ksa_pkg::ST_INSERT)) begin
         fill_count_in = fill_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else begin
         fill_count_ff <= fill_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (status == ksa_pkg::ST_INSERT)) begin
         key_ff[fill_count_ff[IDX_BITS-1:0]] <= key_m;
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= FILL_BITS'(ENTRIES))
      else $error("fill count beyond table size");
   a_fill_insert: assert property (@(posedge clock) disable iff (reset)
      (accept && (status == ksa_pkg::ST_INSERT))
      |=> (fill_count_ff == $past(fill_count_ff) + 1'b1))
      else $error("insert did not advance fill count");
   a_fill_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(fill_count_ff))
      else $error("fill count moved without a transaction");
`endif

endmodule

/* src/ksa_back.sv */
// ksa_back: carries out classified transactions on the totals RAM and drives rsp.
// Depends on ksa_pkg, ksa_stream_if and ksa_ram.
module ksa_back #(
   parameter int ENTRIES    = 16,
   parameter int TOTAL_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  ksa_pkg::work_type          q_work,
   input  logic [$clog2(ENTRIES)-1:0] q_idx,
   output logic                       q_pop,
   ksa_stream_if.source               rsp
);

   localparam int IDX_BITS = $clog2(ENTRIES);
   localparam int TB       = TOTAL_BITS;

   function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] old_v,
                                             input logic [ksa_pkg::INC_BITS-1:0] inc);
      logic [TB:0] sum;
      sum = {1'b0, old_v} + {{(TB + 1 - ksa_pkg::INC_BITS){1'b0}}, inc};
      return sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
   endfunction

   function automatic logic [ksa_pkg::TOTAL_OUT_BITS-1:0] to_out(input logic [TB-1:0] v);
      logic [ksa_pkg::TOTAL_OUT_BITS-1:0] r;
      r = '0;
      for (int b = 0; b < ksa_pkg::TOTAL_OUT_BITS; b++) begin
         if (b < TB) begin
            r[b] = v[b];
         end
      end
      return r;
   endfunction

   function automatic logic [ksa_pkg::SLOT_BITS-1:0] to_slot(input logic [IDX_BITS-1:0] v);
      logic [ksa_pkg::SLOT_BITS-1:0] r;
      r = '0;
      for (int b = 0; b < ksa_pkg::SLOT_BITS; b++) begin
         if (b < IDX_BITS) begin
            r[b] = v[b];
         end
      end
      return r;
   endfunction

   ksa_pkg::back_state_type state_ff, state_in;
   ksa_pkg::work_type       work_ff, work_in;
   logic [IDX_BITS-1:0]     idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ksa_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                    out_free;
   logic                    is_acc;
   logic                    rd_en;
   logic                    wr_en;
   logic [IDX_BITS-1:0]     wr_addr;
   logic [4*TB-1:0]         wr_data;
   logic [4*TB-1:0]         rd_data;
   logic                    load_rsp;
   logic [TB-1:0]           new_games, new_hits, new_bases, new_runs;

   ksa_ram #(
      .WIDTH (4 * TB),
      .DEPTH (ENTRIES)
   ) u_totals (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (q_idx),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign is_acc    = (q_work.status == ksa_pkg::ST_ACCUM);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ksa_pkg::BK_IDLE: begin
            if (!q_empty && is_acc) begin
               state_in = ksa_pkg::BK_READ;
            end
         end
         ksa_pkg::BK_READ: begin
            if (out_free) begin
               state_in = ksa_pkg::BK_IDLE;
            end
         end
         default: state_in = ksa_pkg::BK_IDLE;
      endcase
   end

   // Outputs: queue pop, RAM access and response load.
   always_comb begin
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      load_rsp  = 1'b0;
      work_in   = work_ff;
      idx_in    = idx_ff;
      wr_addr   = q_idx;
      new_games = sat_add('0, q_work.inc_games);
      new_hits  = sat_add('0, q_work.inc_hits);
      new_bases = sat_add('0, q_work.inc_bases);
      new_runs  = sat_add('0, q_work.inc_runs);
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ksa_pkg::BK_IDLE: begin
            if (!q_empty && is_acc) begin
               q_pop   = 1'b1;
               rd_en   = 1'b1;
               work_in = q_work;
               idx_in  = q_idx;
            end else if (!q_empty && out_free) begin
               q_pop    = 1'b1;
               load_rsp = 1'b1;
               wr_en    = (q_work.status == ksa_pkg::ST_INSERT);
               rsp_data_in.status = q_work.status;
               if (q_work.status == ksa_pkg::ST_INSERT) begin
                  rsp_data_in.slot        = to_slot(q_idx);
                  rsp_data_in.total_games = to_out(new_games);
                  rsp_data_in.total_hits  = to_out(new_hits);
                  rsp_data_in.total_bases = to_out(new_bases);
                  rsp_data_in.total_runs  = to_out(new_runs);
               end else begin
                  rsp_data_in.slot        = '0;
                  rsp_data_in.total_games = '0;
                  rsp_data_in.total_hits  = '0;
                  rsp_data_in.total_bases = '0;
                  rsp_data_in.total_runs  = '0;
               end
            end
         end
         ksa_pkg::BK_READ: begin
            // Read data holds while the response side stalls.
            wr_addr   = idx_ff;
            new_games = sat_add(rd_data[4*TB-1 -: TB], work_ff.inc_games);
            new_hits  = sat_add(rd_data[3*TB-1 -: TB], work_ff.inc_hits);
            new_bases = sat_add(rd_data[2*TB-1 -: TB], work_ff.inc_bases);
            new_runs  = sat_add(rd_data[TB-1 -: TB],   work_ff.inc_runs);
            if (out_free) begin
               wr_en    = 1'b1;
               load_rsp = 1'b1;
               rsp_data_in.status      = ksa_pkg::ST_ACCUM;
               rsp_data_in.slot        = to_slot(idx_ff);
               rsp_data_in.total_games = to_out(new_games);
               rsp_data_in.total_hits  = to_out(new_hits);
               rsp_data_in.total_bases = to_out(new_bases);
               rsp_data_in.total_runs  = to_out(new_runs);
            end
         end
         default: ;
      endcase
      wr_data = {new_games, new_hits, new_bases, new_runs};
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ksa_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_data_ff.status == ksa_pkg::ST_FULL) ||
                        (rsp_data_ff.status == ksa_pkg::ST_INVALID)))
      |-> ((rsp_data_ff.slot == '0) && (rsp_data_ff.total_games == '0) &&
           (rsp_data_ff.total_hits == '0) && (rsp_data_ff.total_bases == '0) &&
           (rsp_data_ff.total_runs == '0)))
      else $error("rejected response carries data");
   a_read_then_wait: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (state_ff == ksa_pkg::BK_READ))
      else $error("RAM read without read state");
   a_read_completes: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ksa_pkg::BK_READ) && out_free)
      |=> (rsp_valid_ff && (rsp_data_ff.status == ksa_pkg::ST_ACCUM)))
      else $error("accumulate did not produce a response");
`endif

endmodule

/* bench/ksa_checker.sv */
`timescale 1ns / 100ps
// ksa_checker: watches the request and response channels of the keyed stat
// accumulator, keeps its own copy of the counter table and checks each response.
// Depends on ksa_pkg for the payload and status types.
module ksa_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ksa_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ksa_pkg::rsp_type rsp_data,
   output int               pending,
   output int               fail_count
);
   import ksa_pkg::*;

   localparam int TABLE_SIZE  = 16;

   logic [KEY_IN_BITS-1:0]    key_tab   [TABLE_SIZE];
   logic [TOTAL_OUT_BITS-1:0] games_tab [TABLE_SIZE];
   logic [TOTAL_OUT_BITS-1:0] hits_tab  [TABLE_SIZE];
   logic [TOTAL_OUT_BITS-1:0] bases_tab [TABLE_SIZE];
   logic [TOTAL_OUT_BITS-1:0] runs_tab  [TABLE_SIZE];
   int                        used_slots;
   rsp_type                   tally_q [$];

   function automatic logic [TOTAL_OUT_BITS-1:0] sat_sum(logic [TOTAL_OUT_BITS-1:0] total,
                                                         logic [INC_BITS-1:0] inc);
      logic [TOTAL_OUT_BITS:0] sum;
      sum = {1'b0, total} + (TOTAL_OUT_BITS + 1)'(inc);
      return sum[TOTAL_OUT_BITS] ? '1 : sum[TOTAL_OUT_BITS-1:0];
   endfunction

   // Apply one transaction to the table copy and return the response it earns.
   function automatic rsp_type tally_update(req_type rq);
      rsp_type r;
      int      hit;
      r   = '0;
      hit = -1;
      if (rq.player_key == '0) begin
         r.status = ST_INVALID;
         return r;
      end
      for (int i = 0; i < used_slots; i++) begin
         if (hit < 0 && key_tab[i] == rq.player_key) hit = i;
      end
      if (hit < 0 && used_slots == TABLE_SIZE) begin
         r.status = ST_FULL;
         return r;
      end
      if (hit < 0) begin
         hit            = used_slots;
         key_tab[hit]   = rq.player_key;
         games_tab[hit] = '0;
         hits_tab[hit]  = '0;
         bases_tab[hit] = '0;
         runs_tab[hit]  = '0;
         used_slots++;
         r.status       = ST_INSERT;
      end else begin
         r.status = ST_ACCUM;
      end
      games_tab[hit] = sat_sum(games_tab[hit], rq.inc_games);
      hits_tab[hit]  = sat_sum(hits_tab[hit], rq.inc_hits);
      bases_tab[hit] = sat_sum(bases_tab[hit], rq.inc_bases);
      runs_tab[hit]  = sat_sum(runs_tab[hit], rq.inc_runs);
      r.slot         = hit[SLOT_BITS-1:0];
      r.total_games  = games_tab[hit];
      r.total_hits   = hits_tab[hit];
      r.total_bases  = bases_tab[hit];
      r.total_runs   = runs_tab[hit];
      return r;
   endfunction

   task automatic check_field(string name, logic [TOTAL_OUT_BITS-1:0] want,
                              logic [TOTAL_OUT_BITS-1:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         used_slots = 0;
         tally_q.delete();
      end else begin
         // Retire first: a response never belongs to a request taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (tally_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none, actual %0h",
                        $time, rsp_data);
            end else begin
               want = tally_q.pop_front();
               check_field("status", TOTAL_OUT_BITS'(want.status),
                           TOTAL_OUT_BITS'(rsp_data.status));
               check_field("slot", TOTAL_OUT_BITS'(want.slot),
                           TOTAL_OUT_BITS'(rsp_data.slot));
               check_field("total_games", want.total_games, rsp_data.total_games);
               check_field("total_hits", want.total_hits, rsp_data.total_hits);
               check_field("total_bases", want.total_bases, rsp_data.total_bases);
               check_field("total_runs", want.total_runs, rsp_data.total_runs);
            end
         end
         if (req_valid && req_ready) tally_q.push_back(tally_update(req_data));
      end
      pending <= tally_q.size();
   end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for the keyed stat accumulator.
// Depends on ksa_pkg, ksa_stream_if, keyed_stat_accumulator and ksa_checker.
module tb_top;
   import ksa_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 575;
   localparam int DRAIN_CYCLES   = 20;
   localparam int FILL_KEYS      = 16;

   logic            clock;
   logic            reset;
   int              req_idle_pct;
   int              rsp_idle_pct;
   int              quiet_cycles;
   int              pending;
   int              fail_count;
   logic [15:0]     known_keys [$];
   logic [15:0]     last_key;

   ksa_stream_if #(.T(req_type)) req_ch ();
   ksa_stream_if #(.T(rsp_type)) rsp_ch ();

   keyed_stat_accumulator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ksa_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_data   (req_ch.data),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_data   (rsp_ch.data),
      .pending    (pending),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_tally(logic [15:0] key, logic [15:0] g, logic [15:0] h,
                             logic [15:0] b, logic [15:0] r);
      req_type item;
      logic    taken;
      item = '{player_key: key, inc_games: g, inc_hits: h, inc_bases: b, inc_runs: r};
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= item;
      // Sample ready mid-cycle so the value seen is the one at the next edge.
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
      last_key = key;
   endtask

   // Hold the request side until every outstanding response has come back.
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_inc();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return 16'($urandom_range(15));
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   task automatic random_phase(int count);
      int          sel;
      logic [15:0] key;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         if (sel < 8)
            key = '0;
         else if (sel < 28)
            key = last_key;
         else if (sel < 80)
            key = known_keys[$urandom_range(known_keys.size() - 1)];
         else
            key = 16'($urandom_range(65535));
         send_tally(key, pick_inc(), pick_inc(), pick_inc(), pick_inc());
      end
   endtask

   initial begin
      logic [15:0] key;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      req_idle_pct  = 0;
      rsp_idle_pct  = 0;
      last_key      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // invalid key, first insert, back-to-back accumulate on the same key
      send_tally(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tally(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_tally(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tally(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tally(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_tally(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_tally(16'h0001, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      known_keys.push_back(16'hFFFF);
      known_keys.push_back(16'h0001);
      // fill the rest of the table
      for (int k = 2; k < FILL_KEYS; k++) begin
         key = (16'(k) << 12) | 16'(k);
         known_keys.push_back(key);
         send_tally(key, pick_inc(), pick_inc(), pick_inc(), pick_inc());
      end
      // new key on a full table, invalid key, then a hit on a full table
      send_tally(16'h7777, 16'h1234, 16'h1234, 16'h1234, 16'h1234);
      send_tally(16'h0000, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF);
      send_tally(16'h0001, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      hold_until_drained();

      req_idle_pct = 31;
      rsp_idle_pct = 54;
      random_phase(PHASE_ITEMS);
      hold_until_drained();

      req_idle_pct = 54;
      rsp_idle_pct = 31;
      random_phase(PHASE_ITEMS);
      hold_until_drained();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_phase(PHASE_ITEMS);

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
